@@ rtl/mvsc_pkg.sv @@
// Types, constants and a helper function shared by the start code parser.
package mvsc_pkg;

    localparam logic [2:0] KIND_SEQ     = 3'd0;
    localparam logic [2:0] KIND_GOP     = 3'd1;
    localparam logic [2:0] KIND_PIC     = 3'd2;
    localparam logic [2:0] KIND_SLICE   = 3'd3;
    localparam logic [2:0] KIND_AUDIO   = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;
    localparam logic [2:0] KIND_TRUNC   = 3'd6;

    localparam logic [7:0] SC_PIC         = 8'h00;
    localparam logic [7:0] SC_SLICE_FIRST = 8'h01;
    localparam logic [7:0] SC_SLICE_LAST  = 8'hAF;
    localparam logic [7:0] SC_SEQ         = 8'hB3;
    localparam logic [7:0] SC_GOP         = 8'hB8;
    localparam logic [7:0] SC_AUDIO_FIRST = 8'hE0;
    localparam logic [7:0] SC_AUDIO_LAST  = 8'hEF;

    localparam logic [7:0] PREFIX_ZERO = 8'h00;
    localparam logic [7:0] PREFIX_ONE  = 8'h01;

    localparam logic [3:0] RATE_MIN = 4'd1;
    localparam logic [3:0] RATE_MAX = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  start_code;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [3:0]  rate_code;
        logic        rate_known;
        logic [2:0]  picture_type;
    } t_out_item;

    function automatic logic [2:0] classify(input logic [7:0] code);
        logic [2:0] kind;
        if (code == SC_SEQ) begin
            kind = KIND_SEQ;
        end else if (code == SC_GOP) begin
            kind = KIND_GOP;
        end else if (code == SC_PIC) begin
            kind = KIND_PIC;
        end else if (code >= SC_SLICE_FIRST && code <= SC_SLICE_LAST) begin
            kind = KIND_SLICE;
        end else if (code >= SC_AUDIO_FIRST && code <= SC_AUDIO_LAST) begin
            kind = KIND_AUDIO;
        end else begin
            kind = KIND_UNKNOWN;
        end
        return kind;
    endfunction

endpackage

@@ rtl/mvsc_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transaction.
interface mvsc_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/mvsc_parse_core.sv @@
// Prefix window, header state machine and result decode of the parser.
module mvsc_parse_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  mvsc_pkg::t_in_item  i_item,
    output logic                o_res_valid,
    output mvsc_pkg::t_out_item o_res
);
    import mvsc_pkg::*;

    typedef enum logic [3:0] {
        PH_SCAN = 4'b0001,
        PH_CODE = 4'b0010,
        PH_SEQ  = 4'b0100,
        PH_PIC  = 4'b1000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_win0, r_win1, r_win2;
    logic [7:0] n_win0, n_win1, n_win2;
    logic [7:0] r_held, n_held;
    logic [1:0] r_count, n_count;
    logic [7:0] r_pay [3];
    logic       w_pay_we;
    logic [1:0] w_pay_idx;
    logic [7:0] w_byte;
    logic [3:0] w_rate;

    assign w_byte = i_item.data_byte;
    assign w_rate = w_byte[3:0];

    always_comb begin
        n_phase     = r_phase;
        n_win0      = r_win0;
        n_win1      = r_win1;
        n_win2      = r_win2;
        n_held      = r_held;
        n_count     = r_count;
        w_pay_we    = 1'b0;
        w_pay_idx   = r_count;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_step) begin
            unique case (r_phase)
                PH_SCAN: begin
                    n_win0 = r_win1;
                    n_win1 = r_win2;
                    n_win2 = w_byte;
                    if (r_win1 == PREFIX_ZERO && r_win2 == PREFIX_ZERO &&
                        w_byte == PREFIX_ONE) begin
                        n_phase = PH_CODE;
                        n_count = 2'd0;
                    end
                end
                PH_CODE: begin
                    n_held  = w_byte;
                    n_count = 2'd0;
                    if (w_byte == SC_SEQ) begin
                        n_phase = PH_SEQ;
                    end else if (w_byte == SC_PIC) begin
                        n_phase = PH_PIC;
                    end else begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = classify(w_byte);
                        o_res.start_code = w_byte;
                        n_phase          = PH_SCAN;
                    end
                end
                PH_SEQ: begin
                    if (r_count != 2'd3) begin
                        w_pay_we = 1'b1;
                        n_count  = r_count + 2'd1;
                    end else begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_SEQ;
                        o_res.start_code   = r_held;
                        o_res.frame_width  = {r_pay[0], r_pay[1][7:4]};
                        o_res.frame_height = {r_pay[1][3:0], r_pay[2]};
                        o_res.rate_code    = w_rate;
                        o_res.rate_known   = (w_rate >= RATE_MIN) && (w_rate <= RATE_MAX);
                        n_phase            = PH_SCAN;
                        n_count            = 2'd0;
                    end
                end
                PH_PIC: begin
                    if (r_count == 2'd0) begin
                        w_pay_we = 1'b1;
                        n_count  = 2'd1;
                    end else begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_PIC;
                        o_res.start_code   = r_held;
                        o_res.picture_type = w_byte[5:3];
                        n_phase            = PH_SCAN;
                        n_count            = 2'd0;
                    end
                end
                default: begin
                    n_phase = PH_SCAN;
                end
            endcase

            if (i_item.stream_end) begin
                if (n_phase == PH_SEQ || n_phase == PH_PIC) begin
                    o_res_valid      = 1'b1;
                    o_res            = '0;
                    o_res.kind       = KIND_TRUNC;
                    o_res.start_code = n_held;
                end
                n_phase = PH_SCAN;
                n_win0  = '0;
                n_win1  = '0;
                n_win2  = '0;
                n_held  = '0;
                n_count = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCAN;
            r_win0  <= '0;
            r_win1  <= '0;
            r_win2  <= '0;
            r_held  <= '0;
            r_count <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_win0  <= n_win0;
            r_win1  <= n_win1;
            r_win2  <= n_win2;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            r_pay[w_pay_idx] <= w_byte;
        end
    end

endmodule

@@ rtl/mpeg_video_start_code_parser_unit.sv @@
// Top level of the MPEG video start code and header parser.
// The parser takes one stream byte per clock while not stalled and gives at most one result per
// byte. A byte is captured in an input register, decoded against the prefix window and header
// state, and its result, if any, lands in the output register. Both registers advance together
// whenever the output register is empty or its result is being taken, which keeps the throughput
// at one byte per clock unless the output register holds a result that is not taken.
module mpeg_video_start_code_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mvsc_stream_if.sink   i_in,
    mvsc_stream_if.source o_out
);
    import mvsc_pkg::*;

    logic      w_advance;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_res_valid;
    t_out_item w_res;

    assign w_advance = !r_out_valid || o_out.ready;
    assign i_in.ready = w_advance;

    mvsc_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance && r_in_valid),
        .i_item      (r_in_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_in_valid  <= i_in.valid;
            r_out_valid <= r_in_valid && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_in_item  <= i_in.payload;
            r_out_item <= w_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

@@ tb/tb_mpeg_video_start_code_parser_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the MPEG video start code and header parser.
module tb_mpeg_video_start_code_parser_unit;
    import mvsc_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned TAIL_ITEMS   = 100;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        SCAN_PREFIX,
        READ_CODE,
        READ_SEQ_HDR,
        READ_PIC_HDR
    } t_parse_phase;

    logic i_clk;
    logic i_rst_n;

    mvsc_stream_if #(.T_PAYLOAD(t_in_item))  in_if ();
    mvsc_stream_if #(.T_PAYLOAD(t_out_item)) out_if ();

    mpeg_video_start_code_parser_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_in_item     stream_bytes[$];
    t_out_item    expected_headers[$];
    t_out_item    want_res;
    int unsigned  n_errors = 0;
    int unsigned  n_stream_bytes = 0;
    int unsigned  n_accepted = 0;
    int unsigned  send_gap = 0;
    int unsigned  recv_stall = 0;
    bit           tail_phase = 1'b0;

    logic [7:0]   scan_window[3] = '{8'h00, 8'h00, 8'h00};
    t_parse_phase scan_phase = SCAN_PREFIX;
    logic [7:0]   held_code = 8'h00;
    logic [2:0]   hdr_count = 3'd0;
    logic [7:0]   hdr_bytes[3];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [2:0] code_kind(input logic [7:0] code);
        if (code == SC_SEQ) return KIND_SEQ;
        if (code == SC_GOP) return KIND_GOP;
        if (code == SC_PIC) return KIND_PIC;
        if (code >= SC_SLICE_FIRST && code <= SC_SLICE_LAST) return KIND_SLICE;
        if (code >= SC_AUDIO_FIRST && code <= SC_AUDIO_LAST) return KIND_AUDIO;
        return KIND_UNKNOWN;
    endfunction

    function automatic void parse_byte(input t_in_item item);
        t_out_item  res;
        bit         have;
        logic [7:0] b;
        b    = item.data_byte;
        res  = '0;
        have = 1'b0;
        case (scan_phase)
            SCAN_PREFIX: begin
                scan_window[0] = scan_window[1];
                scan_window[1] = scan_window[2];
                scan_window[2] = b;
                if (scan_window[0] == PREFIX_ZERO && scan_window[1] == PREFIX_ZERO &&
                    scan_window[2] == PREFIX_ONE) begin
                    scan_phase = READ_CODE;
                    hdr_count  = 3'd0;
                end
            end
            READ_CODE: begin
                held_code = b;
                hdr_count = 3'd0;
                if (b == SC_SEQ) begin
                    scan_phase = READ_SEQ_HDR;
                end else if (b == SC_PIC) begin
                    scan_phase = READ_PIC_HDR;
                end else begin
                    res.kind       = code_kind(b);
                    res.start_code = b;
                    have           = 1'b1;
                    scan_phase     = SCAN_PREFIX;
                end
            end
            READ_SEQ_HDR: begin
                if (hdr_count < 3'd3) begin
                    hdr_bytes[hdr_count] = b;
                    hdr_count++;
                end else begin
                    res.kind         = KIND_SEQ;
                    res.start_code   = held_code;
                    res.frame_width  = {hdr_bytes[0], hdr_bytes[1][7:4]};
                    res.frame_height = {hdr_bytes[1][3:0], hdr_bytes[2]};
                    res.rate_code    = b[3:0];
                    res.rate_known   = (b[3:0] >= RATE_MIN) && (b[3:0] <= RATE_MAX);
                    have             = 1'b1;
                    scan_phase       = SCAN_PREFIX;
                    hdr_count        = 3'd0;
                end
            end
            default: begin
                if (hdr_count == 3'd0) begin
                    hdr_bytes[0] = b;
                    hdr_count    = 3'd1;
                end else begin
                    res.kind         = KIND_PIC;
                    res.start_code   = held_code;
                    res.picture_type = b[5:3];
                    have             = 1'b1;
                    scan_phase       = SCAN_PREFIX;
                    hdr_count        = 3'd0;
                end
            end
        endcase
        if (item.stream_end) begin
            if (scan_phase == READ_SEQ_HDR || scan_phase == READ_PIC_HDR) begin
                res            = '0;
                res.kind       = KIND_TRUNC;
                res.start_code = held_code;
                have           = 1'b1;
            end
            scan_window = '{8'h00, 8'h00, 8'h00};
            scan_phase  = SCAN_PREFIX;
            held_code   = 8'h00;
            hdr_count   = 3'd0;
        end
        if (have) expected_headers.push_back(res);
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit last);
        t_in_item item;
        item.data_byte  = b;
        item.stream_end = last;
        stream_bytes.push_back(item);
        n_stream_bytes++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Driver: presents queued bytes, holding each until it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                parse_byte(in_if.payload);
                n_accepted++;
            end
            tail_phase <= (stream_bytes.size() < TAIL_ITEMS);
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (stream_bytes.size() > 0 && !tail_phase &&
                             $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    in_if.valid <= 1'b0;
                end else if (stream_bytes.size() > 0) begin
                    in_if.valid   <= 1'b1;
                    in_if.payload <= stream_bytes.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and applies random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_headers.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d code 0x%0h",
                             $time, out_if.payload.kind, out_if.payload.start_code);
                    n_errors++;
                end else begin
                    want_res = expected_headers.pop_front();
                    check_field("kind", want_res.kind, out_if.payload.kind);
                    check_field("start_code", want_res.start_code, out_if.payload.start_code);
                    check_field("frame_width", want_res.frame_width,
                                out_if.payload.frame_width);
                    check_field("frame_height", want_res.frame_height,
                                out_if.payload.frame_height);
                    check_field("rate_code", want_res.rate_code, out_if.payload.rate_code);
                    check_field("rate_known", want_res.rate_known, out_if.payload.rate_known);
                    check_field("picture_type", want_res.picture_type,
                                out_if.payload.picture_type);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_if.ready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 10);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0]  unit_bytes[$];
        logic [7:0]  code;
        int unsigned n_random;
        int unsigned cut;
        int unsigned pick;

        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        out_if.ready   = 1'b0;

        // Overlapping prefix, then a sequence header with all-zero sizes.
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h01, 0);
        push_byte(SC_SEQ, 0);
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h08, 0);
        // Picture header with every coding type bit set.
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h01, 0);
        push_byte(SC_PIC, 0); push_byte(8'hFF, 0); push_byte(8'hFF, 0);
        // Stream ends on the first byte of a sequence header, an all-ones size byte.
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h01, 0);
        push_byte(SC_SEQ, 0); push_byte(8'hFF, 1);
        // Stream ends right after a prefix.
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h01, 1);
        // Unknown code on the last byte of a stream.
        push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h01, 0); push_byte(8'hFF, 1);

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            unit_bytes.delete();
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(0, 3)) unit_bytes.push_back($urandom_range(0, 255));
                unit_bytes.push_back(PREFIX_ZERO);
                unit_bytes.push_back(PREFIX_ZERO);
                unit_bytes.push_back(PREFIX_ONE);
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1: code = SC_SEQ;
                    2, 3: code = SC_PIC;
                    4:    code = SC_GOP;
                    5, 6: code = $urandom_range(SC_SLICE_FIRST, SC_SLICE_LAST);
                    7:    code = $urandom_range(SC_AUDIO_FIRST, SC_AUDIO_LAST);
                    default: code = $urandom_range(0, 255);
                endcase
                unit_bytes.push_back(code);
                if (code == SC_SEQ) begin
                    case ($urandom_range(0, 5))
                        0: repeat (3) unit_bytes.push_back(8'hFF);
                        1: repeat (3) unit_bytes.push_back(8'h00);
                        default: repeat (3) unit_bytes.push_back($urandom_range(0, 255));
                    endcase
                    unit_bytes.push_back($urandom_range(0, 255));
                end else if (code == SC_PIC) begin
                    repeat (2) unit_bytes.push_back($urandom_range(0, 255));
                end
                if ($urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(0, unit_bytes.size() - 1);
                end else if ($urandom_range(0, 14) == 0) begin
                    cut = unit_bytes.size() - 1;
                end else begin
                    cut = unit_bytes.size();
                end
                for (int i = 0; i < unit_bytes.size() && i <= cut; i++) begin
                    push_byte(unit_bytes[i], i == cut);
                    n_random++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0, 1: code = PREFIX_ZERO;
                        2:    code = PREFIX_ONE;
                        default: code = $urandom_range(0, 255);
                    endcase
                    push_byte(code, $urandom_range(0, 19) == 0);
                    n_random++;
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_stream_bytes) @(posedge i_clk);
        while (expected_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb_mpeg_video_start_code_parser_unit: done, clean");
        end else begin
            $display("tb_mpeg_video_start_code_parser_unit: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_headers.size());
        $display("tb_mpeg_video_start_code_parser_unit: done, errors");
        $finish;
    end

endmodule
